// ----- hdl/tms_pkg.sv -----
`timescale 1ns / 1ps
// tms_pkg: shared types, codes and constants of the tone melody sequencer
// no dependencies; imported by every module of the block except tms_ram

package tms_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int POS_W           = 10;
   localparam int ENTRY_SUM_W     = POS_W + 1;
   localparam int CODE_W          = 7;
   localparam int NOTE_W          = 8;
   localparam int DUR_W           = 16;
   localparam int ELAPSED_W       = 17;
   localparam int FREQ_W          = 12;
   localparam int STEP_W          = 10;
   localparam int WRAP_STEPS      = 8;
   localparam int RSP_DEPTH       = 2;

   localparam logic [NOTE_W-1:0]    MAX_CODE      = 8'd99;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
   localparam logic [STEP_W-1:0]    STEP_MS_RESET = 10'd11;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_STEP_MS = 1'b0;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_LOAD   = 3'd1,
      FUNC_PLAY   = 3'd2,
      FUNC_STOP   = 3'd3,
      FUNC_PAUSE  = 3'd4,
      FUNC_RESUME = 3'd5,
      FUNC_SEEK   = 3'd6,
      FUNC_EFFECT = 3'd7
   } func_type;

   typedef struct packed {
      func_type                 func;
      logic [POS_W-1:0]         address;
      logic signed [NOTE_W-1:0] note_code;
      logic [DUR_W-1:0]         duration_ms;
      logic                     loop_enable;
   } req_type;

   typedef struct packed {
      logic              tone_on;
      logic [FREQ_W-1:0] tone_freq;
      logic              playing;
      logic              effect_active;
      logic              song_ended;
      logic [POS_W-1:0]  position;
   } rsp_type;

   // note frequencies in hertz, codes 1 to 10 are silent entries
   localparam logic [FREQ_W-1:0] FREQ_ROM [100] = '{
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd0,    12'd0,    12'd0,    12'd15,   12'd16,   12'd17,   12'd18,   12'd19,
      12'd21,   12'd22,   12'd23,   12'd25,   12'd26,   12'd28,   12'd29,   12'd31,
      12'd33,   12'd35,   12'd37,   12'd39,   12'd41,   12'd44,   12'd46,   12'd49,
      12'd52,   12'd55,   12'd58,   12'd62,   12'd65,   12'd69,   12'd73,   12'd78,
      12'd82,   12'd87,   12'd92,   12'd98,   12'd104,  12'd110,  12'd117,  12'd123,
      12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,  12'd185,  12'd196,
      12'd208,  12'd220,  12'd233,  12'd247,  12'd262,  12'd277,  12'd294,  12'd311,
      12'd330,  12'd349,  12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
      12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,  12'd740,  12'd784,
      12'd831,  12'd880,  12'd932,  12'd988,  12'd1047, 12'd1109, 12'd1175, 12'd1245,
      12'd1319, 12'd1397, 12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
      12'd2093, 12'd2218, 12'd2349, 12'd2489
   };

   // effective note code: codes above the table play as silence
   function automatic logic [CODE_W-1:0] note_code_of(input logic [NOTE_W-1:0] raw);
      logic [CODE_W-1:0] code;
      code = raw[CODE_W-1:0];
      if (raw[NOTE_W-1] || (raw > MAX_CODE)) begin
         code = '0;
      end
      return code;
   endfunction

   // sum modulo depth by binary compare and subtract, sum stays below 16 * 128
   function automatic logic [ENTRY_SUM_W-1:0] wrap_entry(input logic [ENTRY_SUM_W-1:0] sum,
                                                         input logic [31:0] depth);
      logic [31:0] v;
      v = {{(32-ENTRY_SUM_W){1'b0}}, sum};
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
         if (v >= (depth << k)) begin
            v = v - (depth << k);
         end
      end
      return v[ENTRY_SUM_W-1:0];
   endfunction

endpackage

// ----- hdl/tone_melody_sequencer.sv -----
`timescale 1ns / 1ps
// tone_melody_sequencer: top level with the step_ms control register
// depends on tms_pkg, tms_engine, tms_rsp_fifo
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries commands: tick, load
//   entry, play song, stop, pause, resume, seek and play effect. Every
//   transaction returns exactly one result on the rsp channel
//   (rsp_valid/rsp_ready/rsp_data) with speaker, run flags and position.
//   The APB port holds step_ms at byte address 0; pready is always high.
//   Results are registered in the result buffer before they are offered.
//   A new transaction is not taken until the last one has executed. A tick
//   reads the current and following note entries and then updates the track
//   state, and the following transaction's entry address depends on it.
//   Results queue in a two-entry buffer, so a new transaction is taken while
//   one result waits; req_ready is low in the cycle after each taken
//   transaction and while both entries are held.
//   Reset: track state, flags, saved context and speaker clear, step_ms
//   becomes 11. Note and duration entries are undefined until loaded.
//   Stalling the receiver holds rsp_data stable until it is taken.

module tone_melody_sequencer import tms_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [STEP_W-1:0] step_ms_ff, step_ms_in;
   logic              csr_write;
   logic              push_valid;
   rsp_type           push_data;
   logic              rsp_room;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      step_ms_in = step_ms_ff;
      if (csr_write && (paddr[CSR_ADDR_W-1:2] == REG_STEP_MS)) begin
         step_ms_in = pwdata[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ms_ff <= STEP_MS_RESET;
      end else begin
         step_ms_ff <= step_ms_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_STEP_MS) ?
                   CSR_DATA_W'(step_ms_ff) : '0;

   tms_engine #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_ms    (step_ms_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_room   (rsp_room),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tms_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .room       (rsp_room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- hdl/tms_ram.sv -----
`timescale 1ns / 1ps
// tms_ram: generic single-write, single-read memory with registered read data
// no dependencies

module tms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tms_rsp_fifo.sv -----
`timescale 1ns / 1ps
// tms_rsp_fifo: two-entry result queue between the engine and the rsp channel
// depends on tms_pkg

module tms_rsp_fifo import tms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    room,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type          slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign room      = (count_ff < CNT_W'(RSP_DEPTH));

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // the engine only starts a transaction when a slot is guaranteed
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != CNT_W'(RSP_DEPTH)))
      else $error("result pushed into a full queue");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("queue count out of range");

endmodule

// ----- hdl/tms_engine.sv -----
`timescale 1ns / 1ps
// tms_engine: entry memories, track state and the per-transaction update
// depends on tms_pkg, tms_ram

module tms_engine import tms_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] step_ms,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_room,
   output logic              push_valid,
   output rsp_type           push_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

   typedef struct packed {
      logic [POS_W-1:0]     base;
      logic [POS_W-1:0]     pos;
      logic [CODE_W-1:0]    last;
      logic [ELAPSED_W-1:0] elapsed;
   } track_type;

   typedef struct packed {
      track_type trk;
      logic      loop;
      logic      valid;
   } save_type;

   typedef struct packed {
      logic playing;
      logic loop;
      logic effect;
      logic ended;
   } flags_type;

   track_type         ctx_ff, ctx_in;
   save_type          sv_ff, sv_in;
   flags_type         flags_ff, flags_in;
   logic              tone_on_ff, tone_on_in;
   logic [FREQ_W-1:0] tone_freq_ff, tone_freq_in;
   req_type           item_ff;
   logic              exec_valid_ff;

   logic                   req_fire;
   logic                   load_en;
   logic [POS_W-1:0]       pos_inc;
   logic [AW-1:0]          cur_addr, next_addr, load_addr;
   logic [NOTE_W+DUR_W-1:0] cur_word;
   logic [NOTE_W-1:0]      next_note;
   logic                   cur_end, next_end;
   logic [CODE_W-1:0]      cur_code, next_code;
   logic                   advance;
   logic [ELAPSED_W:0]     elapsed_sum;
   logic [ELAPSED_W-1:0]   elapsed_sat;

   assign req_ready = !exec_valid_ff && rsp_room;
   assign req_fire  = req_valid && req_ready;
   assign load_en   = req_fire && (req_data.func == FUNC_LOAD);

   // entry address of the current and the following position
   assign pos_inc   = ctx_ff.pos + 1'b1;
   assign cur_addr  = AW'(wrap_entry({1'b0, ctx_ff.base} + {1'b0, ctx_ff.pos}, DEPTH_W));
   assign next_addr = AW'(wrap_entry({1'b0, ctx_ff.base} + {1'b0, pos_inc}, DEPTH_W));
   assign load_addr = AW'(wrap_entry({1'b0, req_data.address}, DEPTH_W));

   tms_ram #(
      .WIDTH (NOTE_W + DUR_W),
      .DEPTH (STORE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data ({req_data.note_code, req_data.duration_ms}),
      .rd_addr (cur_addr),
      .rd_data (cur_word)
   );

   // copy of the note codes so the following entry is read in the same cycle
   tms_ram #(
      .WIDTH (NOTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_data.note_code),
      .rd_addr (next_addr),
      .rd_data (next_note)
   );

   assign cur_end   = cur_word[NOTE_W+DUR_W-1];
   assign cur_code  = note_code_of(cur_word[NOTE_W+DUR_W-1:DUR_W]);
   assign next_end  = next_note[NOTE_W-1];
   assign next_code = note_code_of(next_note);
   assign advance   = (ctx_ff.elapsed >= {1'b0, cur_word[DUR_W-1:0]});

   assign elapsed_sum = {1'b0, ctx_ff.elapsed} + (ELAPSED_W+1)'(step_ms) + 1'b1;
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];

   always_comb begin
      ctx_in       = ctx_ff;
      sv_in        = sv_ff;
      flags_in     = flags_ff;
      tone_on_in   = tone_on_ff;
      tone_freq_in = tone_freq_ff;
      if (exec_valid_ff) begin
         unique case (item_ff.func)
            FUNC_TICK: begin
               if (!flags_ff.playing) begin
                  tone_on_in   = 1'b0;
                  tone_freq_in = '0;
               end else if (!cur_end) begin
                  if (cur_code != '0) begin
                     if (cur_code != ctx_ff.last) begin
                        tone_on_in   = 1'b1;
                        tone_freq_in = FREQ_ROM[cur_code];
                        ctx_in.last  = cur_code;
                     end
                  end else begin
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                     ctx_in.last  = '0;
                  end
                  if (advance) begin
                     ctx_in.pos     = pos_inc;
                     ctx_in.elapsed = '0;
                     // repeated note: drop the tone for one tick
                     if (!next_end && (next_code == ctx_in.last)) begin
                        tone_on_in   = 1'b0;
                        tone_freq_in = '0;
                        ctx_in.last  = '0;
                     end
                  end else begin
                     ctx_in.elapsed = elapsed_sat;
                  end
               end else begin
                  tone_on_in   = 1'b0;
                  tone_freq_in = '0;
                  if (flags_ff.effect) begin
                     flags_in.effect = 1'b0;
                     if (sv_ff.valid) begin
                        ctx_in           = sv_ff.trk;
                        flags_in.loop    = sv_ff.loop;
                        flags_in.playing = 1'b1;
                        sv_in.valid      = 1'b0;
                     end else begin
                        flags_in.playing = 1'b0;
                     end
                  end else if (flags_ff.loop) begin
                     ctx_in.pos     = '0;
                     ctx_in.last    = '0;
                     ctx_in.elapsed = '0;
                  end else begin
                     flags_in.ended   = 1'b1;
                     flags_in.playing = 1'b0;
                  end
               end
            end
            FUNC_LOAD: begin
               // the store write happened when the transaction was taken
               ctx_in = ctx_ff;
            end
            FUNC_PLAY: begin
               ctx_in.base      = item_ff.address;
               ctx_in.pos       = '0;
               ctx_in.last      = '0;
               ctx_in.elapsed   = '0;
               flags_in.loop    = item_ff.loop_enable;
               flags_in.playing = 1'b1;
               flags_in.ended   = 1'b0;
               flags_in.effect  = 1'b0;
               sv_in.valid      = 1'b0;
            end
            FUNC_STOP: begin
               tone_on_in       = 1'b0;
               tone_freq_in     = '0;
               ctx_in.pos       = '0;
               ctx_in.last      = '0;
               ctx_in.elapsed   = '0;
               flags_in.playing = 1'b0;
               flags_in.effect  = 1'b0;
               flags_in.ended   = 1'b0;
               sv_in.valid      = 1'b0;
            end
            FUNC_PAUSE: begin
               tone_on_in       = 1'b0;
               tone_freq_in     = '0;
               flags_in.playing = 1'b0;
            end
            FUNC_RESUME: begin
               flags_in.playing = 1'b1;
            end
            FUNC_SEEK: begin
               ctx_in.pos = item_ff.address;
            end
            FUNC_EFFECT: begin
               // a nested effect keeps the song context saved by the first one
               if (!flags_ff.effect) begin
                  if (flags_ff.playing) begin
                     sv_in.trk   = ctx_ff;
                     sv_in.loop  = flags_ff.loop;
                     sv_in.valid = 1'b1;
                  end else begin
                     sv_in.valid = 1'b0;
                  end
               end
               ctx_in.base      = item_ff.address;
               ctx_in.pos       = '0;
               ctx_in.last      = '0;
               ctx_in.elapsed   = '0;
               flags_in.playing = 1'b1;
               flags_in.effect  = 1'b1;
            end
         endcase
      end
   end

   assign push_valid              = exec_valid_ff;
   assign push_data.tone_on       = tone_on_in;
   assign push_data.tone_freq     = tone_freq_in;
   assign push_data.playing       = flags_in.playing;
   assign push_data.effect_active = flags_in.effect;
   assign push_data.song_ended    = flags_in.ended;
   assign push_data.position      = ctx_in.pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff        <= '0;
         sv_ff         <= '0;
         flags_ff      <= '0;
         tone_on_ff    <= 1'b0;
         tone_freq_ff  <= '0;
         exec_valid_ff <= 1'b0;
      end else begin
         ctx_ff        <= ctx_in;
         sv_ff         <= sv_in;
         flags_ff      <= flags_in;
         tone_on_ff    <= tone_on_in;
         tone_freq_ff  <= tone_freq_in;
         exec_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
   end

   a_saved_only_in_effect: assert property (@(posedge clock) disable iff (reset)
      sv_ff.valid |-> flags_ff.effect)
      else $error("saved song context without an active effect");

   a_tone_needs_play: assert property (@(posedge clock) disable iff (reset)
      tone_on_ff |-> flags_ff.playing)
      else $error("tone enabled while the sequencer is stopped");

   a_silent_freq: assert property (@(posedge clock) disable iff (reset)
      !tone_on_ff |-> (tone_freq_ff == '0))
      else $error("frequency left over after tone off");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      exec_valid_ff |-> !req_ready)
      else $error("transaction taken while the memories are busy");

endmodule

// ----- tb/sv/tb_tone_melody_sequencer.sv -----
`timescale 1ns / 1ps
// tb_tone_melody_sequencer: self-checking testbench for the tone melody sequencer
// drives commands and step_ms, predicts and checks every status transaction
// depends on tms_pkg and tone_melody_sequencer

module tb_tone_melody_sequencer;
   import tms_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 480;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tone_melody_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // player prediction state
   logic [NOTE_W-1:0]    note_mem [STORE_DEPTH_DEF];
   logic [DUR_W-1:0]     dur_mem  [STORE_DEPTH_DEF];
   bit                   written  [STORE_DEPTH_DEF];
   logic [STEP_W-1:0]    ms_step;
   logic [POS_W-1:0]     song_base, song_pos, ctx_base, ctx_pos;
   logic [CODE_W-1:0]    held_note, ctx_note;
   logic [ELAPSED_W-1:0] ms_count, ctx_ms;
   bit                   run, looping, fx_on, finished, ctx_looping, ctx_ok;
   bit                   spk_on;
   logic [FREQ_W-1:0]    spk_freq;

   rsp_type expected_status [$];
   int      fail_count = 0;
   int      items_sent = 0;
   int      cycle_count = 0;
   bit      gaps_on = 1'b1;
   int      stall_request = 0;

   function automatic int effective_code(logic [NOTE_W-1:0] raw);
      if (raw[NOTE_W-1]) return -1;
      if (raw > MAX_CODE) return 0;
      return int'(raw);
   endfunction

   function automatic void speaker_off();
      spk_on   = 1'b0;
      spk_freq = '0;
   endfunction

   function automatic void rewind();
      song_pos  = '0;
      held_note = '0;
      ms_count  = '0;
   endfunction

   function automatic void reset_player();
      ms_step     = STEP_MS_RESET;
      song_base   = '0;
      rewind();
      run         = 1'b0;
      looping     = 1'b0;
      fx_on       = 1'b0;
      finished    = 1'b0;
      ctx_base    = '0;
      ctx_pos     = '0;
      ctx_note    = '0;
      ctx_ms      = '0;
      ctx_looping = 1'b0;
      ctx_ok      = 1'b0;
      speaker_off();
   endfunction

   function automatic void play_tick();
      logic [POS_W-1:0] slot;
      int code, following, sum;
      if (!run) begin
         speaker_off();
         return;
      end
      slot = song_base + song_pos;
      code = effective_code(note_mem[slot]);
      if (code < 0) begin
         speaker_off();
         if (fx_on) begin
            fx_on = 1'b0;
            if (ctx_ok) begin
               song_base = ctx_base;
               song_pos  = ctx_pos;
               held_note = ctx_note;
               ms_count  = ctx_ms;
               looping   = ctx_looping;
               ctx_ok    = 1'b0;
               run       = 1'b1;
            end else begin
               run = 1'b0;
            end
         end else if (looping) begin
            rewind();
         end else begin
            finished = 1'b1;
            run      = 1'b0;
         end
         return;
      end
      if (code == 0) begin
         speaker_off();
         held_note = '0;
      end else if (code != int'(held_note)) begin
         spk_on    = 1'b1;
         spk_freq  = FREQ_ROM[code];
         held_note = code[CODE_W-1:0];
      end
      if (ms_count >= dur_mem[slot]) begin
         song_pos  = song_pos + 1'b1;
         slot      = song_base + song_pos;
         following = effective_code(note_mem[slot]);
         // same note next: drop the tone for one tick
         if (following == int'(held_note)) begin
            speaker_off();
            held_note = '0;
         end
         ms_count = '0;
      end else begin
         sum = int'(ms_count) + int'(ms_step) + 1;
         ms_count = (sum > int'(ELAPSED_MAX)) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      end
   endfunction

   function automatic void advance_player(req_type t);
      rsp_type status;
      case (t.func)
         FUNC_TICK: play_tick();
         FUNC_LOAD: begin
            note_mem[t.address] = t.note_code;
            dur_mem[t.address]  = t.duration_ms;
            written[t.address]  = 1'b1;
         end
         FUNC_PLAY: begin
            song_base = t.address;
            rewind();
            looping  = t.loop_enable;
            run      = 1'b1;
            finished = 1'b0;
            fx_on    = 1'b0;
            ctx_ok   = 1'b0;
         end
         FUNC_STOP: begin
            speaker_off();
            run = 1'b0;
            rewind();
            fx_on    = 1'b0;
            ctx_ok   = 1'b0;
            finished = 1'b0;
         end
         FUNC_PAUSE: begin
            speaker_off();
            run = 1'b0;
         end
         FUNC_RESUME: run = 1'b1;
         FUNC_SEEK: song_pos = t.address;
         default: begin
            // a nested effect keeps the song context saved by the first one
            if (!fx_on) begin
               if (run) begin
                  ctx_base    = song_base;
                  ctx_pos     = song_pos;
                  ctx_note    = held_note;
                  ctx_ms      = ms_count;
                  ctx_looping = looping;
                  ctx_ok      = 1'b1;
               end else begin
                  ctx_ok = 1'b0;
               end
            end
            song_base = t.address;
            rewind();
            run   = 1'b1;
            fx_on = 1'b1;
         end
      endcase
      status.tone_on       = spk_on;
      status.tone_freq     = spk_freq;
      status.playing       = run;
      status.effect_active = fx_on;
      status.song_ended    = finished;
      status.position      = song_pos;
      expected_status.push_back(status);
   endfunction

   function automatic int pick_note(bit allow_end);
      int r;
      r = $urandom_range(0, 99);
      if (allow_end && r < 10) return -int'($urandom_range(1, 128));
      if (r < 20) return 0;
      if (r < 30) return $urandom_range(1, 10);
      if (r < 38) return $urandom_range(100, 127);
      return $urandom_range(11, 99);
   endfunction

   function automatic int pick_duration();
      if ($urandom_range(0, 99) < 2) return $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) return 0;
      return $urandom_range(0, 3 * (int'(ms_step) + 1));
   endfunction

   function automatic req_type make_load(int slot, int note, int dur);
      req_type t;
      t.func        = FUNC_LOAD;
      t.address     = slot[POS_W-1:0];
      t.note_code   = note[NOTE_W-1:0];
      t.duration_ms = dur[DUR_W-1:0];
      t.loop_enable = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic req_type make_cmd(func_type f, int slot, bit lp);
      req_type t;
      t.func        = f;
      t.address     = slot[POS_W-1:0];
      t.note_code   = NOTE_W'($urandom_range(0, 255));
      t.duration_ms = DUR_W'($urandom_range(0, 65535));
      t.loop_enable = lp;
      return t;
   endfunction

   // one transaction on the request channel, predicted at the accepting edge
   task automatic offer(input req_type t);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_player(t);
      items_sent++;
   endtask

   // a tick reads the current and following entry, so whichever is unwritten is loaded first
   task automatic send_item(input req_type t);
      logic [POS_W-1:0] slot;
      if (t.func == FUNC_TICK) begin
         for (int k = 0; k < 2; k++) begin
            slot = song_base + song_pos + POS_W'(k);
            if (!written[slot]) offer(make_load(int'(slot), pick_note(1'b1), pick_duration()));
         end
      end
      offer(t);
   endtask

   task automatic load_entry(input int slot, input int note, input int dur);
      send_item(make_load(slot, note, dur));
   endtask

   task automatic command(input func_type f, input int slot, input bit lp);
      send_item(make_cmd(f, slot, lp));
   endtask

   task automatic tick();
      command(FUNC_TICK, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
   endtask

   task automatic load_track(input int base, input int len);
      int note, prev;
      prev = 0;
      for (int i = 0; i < len; i++) begin
         note = ($urandom_range(0, 3) == 0) ? prev : pick_note(1'b0);
         load_entry(base + i, note, pick_duration());
         prev = note;
      end
      load_entry(base + len, -int'($urandom_range(1, 128)), pick_duration());
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input int value);
      wait_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(REG_STEP_MS));
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ms_step = value[STEP_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read();
      @(negedge clock);
      req_valid <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * int'(REG_STEP_MS));
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(ms_step)) begin
         $error("step_ms read mismatch: expected %0d, got %0d", ms_step, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            $error("status transaction with no command pending");
            fail_count++;
         end else begin
            want = expected_status.pop_front();
            check_field("tone_on", 32'(want.tone_on), 32'(rsp_data.tone_on));
            check_field("tone_freq", 32'(want.tone_freq), 32'(rsp_data.tone_freq));
            check_field("playing", 32'(want.playing), 32'(rsp_data.playing));
            check_field("effect_active", 32'(want.effect_active),
                        32'(rsp_data.effect_active));
            check_field("song_ended", 32'(want.song_ended), 32'(rsp_data.song_ended));
            check_field("position", 32'(want.position), 32'(rsp_data.position));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : receiver
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            hold = stall_request;
            stall_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 20);
      end
   end

   task automatic test_step_register();
      csr_read();
      csr_write(1000);
      csr_read();
      csr_write(1);
      csr_read();
   endtask

   task automatic test_idle_tick();
      command(FUNC_TICK, 0, 1'b0);
      command(FUNC_TICK, 1023, 1'b1);
   endtask

   // track across the top of memory: repeated note, code above the table,
   // silent low code, silence and end marker, no loop
   task automatic test_song_edges();
      load_entry(1021, 99, 0);
      load_entry(1022, 99, 0);
      load_entry(1023, 127, 0);
      load_entry(0, 5, 0);
      load_entry(1, 0, 0);
      load_entry(2, -128, 65535);
      command(FUNC_PLAY, 1021, 1'b0);
      repeat (7) tick();
   endtask

   task automatic test_transport_commands();
      command(FUNC_PLAY, 1021, 1'b1);
      command(FUNC_PAUSE, 0, 1'b0);
      tick();
      command(FUNC_RESUME, 0, 1'b0);
      command(FUNC_SEEK, 4, 1'b0);
      tick();
      tick();
      command(FUNC_SEEK, 1023, 1'b0);
      tick();
      command(FUNC_STOP, 0, 1'b0);
   endtask

   task automatic test_effects();
      load_entry(1000, 60, 0);
      load_entry(1001, -1, 0);
      command(FUNC_PLAY, 1021, 1'b0);
      tick();
      command(FUNC_EFFECT, 1000, 1'b0);
      command(FUNC_EFFECT, 1000, 1'b1);
      tick();
      tick();
      tick();
      command(FUNC_STOP, 0, 1'b0);
      command(FUNC_EFFECT, 1000, 1'b0);
      tick();
      tick();
   endtask

   task automatic test_flow_control();
      int base;
      base = $urandom_range(0, 1023);
      load_track(base, 4);
      command(FUNC_PLAY, base, 1'b1);
      // receiver holds off while the sender keeps going
      stall_request = 64;
      repeat (20) tick();
      wait_idle();
      repeat (4) tick();
   endtask

   task automatic test_burst();
      int base;
      gaps_on = 1'b0;
      base = $urandom_range(0, 1023);
      load_track(base, 6);
      command(FUNC_PLAY, base, 1'b1);
      repeat (90) begin
         if ($urandom_range(0, 19) == 0) command(FUNC_SEEK, $urandom_range(0, 7), 1'b0);
         else tick();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_songs();
      int base, len, fx, r, phase;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0) csr_write(1000);
         else if (phase == 1) csr_write(11);
         else if ($urandom_range(0, 3) == 0) csr_write($urandom_range(1, 1000));
         if (phase < 2 || $urandom_range(0, 3) == 0) csr_read();
         base = $urandom_range(0, 1023);
         len  = $urandom_range(1, 8);
         load_track(base, len);
         command(FUNC_PLAY, base, 1'($urandom_range(0, 1)));
         repeat ($urandom_range(10, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 72) tick();
            else if (r < 77) command(FUNC_PAUSE, $urandom_range(0, 1023), 1'b0);
            else if (r < 82) command(FUNC_RESUME, $urandom_range(0, 1023), 1'b0);
            else if (r < 86) begin
               if ($urandom_range(0, 4) == 0) command(FUNC_SEEK, $urandom_range(0, 1023), 1'b0);
               else command(FUNC_SEEK, $urandom_range(0, len + 1), 1'b0);
            end else if (r < 92) begin
               fx = $urandom_range(0, 1023);
               load_track(fx, $urandom_range(1, 3));
               command(FUNC_EFFECT, fx, 1'($urandom_range(0, 1)));
            end else if (r < 94) command(FUNC_STOP, $urandom_range(0, 1023), 1'b0);
            else if (r < 96) command(FUNC_PLAY, base, 1'($urandom_range(0, 1)));
            else begin
               // noise: any command with random fields
               if ($urandom_range(0, 1) == 0) begin
                  load_entry($urandom_range(0, 1023), pick_note(1'b1), $urandom_range(0, 65535));
               end else begin
                  command(func_type'($urandom_range(0, 7)), $urandom_range(0, 1023),
                          1'($urandom_range(0, 1)));
               end
            end
         end
         phase++;
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      reset_player();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_step_register();
      test_idle_tick();
      test_song_edges();
      test_transport_commands();
      test_effects();
      test_flow_control();
      test_burst();
      test_random_songs();

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
